>>> rtl/sust_pkg.sv
// ----------------------------------------------------------------------------
// sust_pkg: shared types and constants for the sorted unique set table
// Capacity, field widths, action codes and the controller command struct.
// ----------------------------------------------------------------------------
package sust_pkg;

    localparam int CAPACITY  = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ACT_W     = 2;
    localparam int VAL_W     = 32;
    localparam int OUT_CNT_W = 5;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch item and register compare vectors
        logic commit;    // apply shift, update count, load result
    } cmd_t;

endpackage

>>> rtl/sorted_unique_set_table_top.sv
// ----------------------------------------------------------------------------
// sorted_unique_set_table_top: sorted set of distinct signed 32-bit keys
// Fixed store of sust_pkg::CAPACITY entries kept ascending in registers.
// The key is compared at accept and the result register is loaded at commit,
//   in the update state; the commit waits while a held result is not taken.
// One item at a time: the shift must land before the next compare, so the
//   input stays closed during the update state.
// Output backpressure stalls only the commit; a result may wait while the
//   next item is accepted. Reset (async, rst_n low) empties the set.
// ----------------------------------------------------------------------------
module sorted_unique_set_table_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // request channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic        [sust_pkg::ACT_W-1:0]     action,
    input  logic signed [sust_pkg::VAL_W-1:0]     value,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit,
    output logic                                  status,
    output logic        [sust_pkg::OUT_CNT_W-1:0] count
);

    // command bundle from sequencer to datapath:
    //   capture - item accepted, key compared against all held entries
    //   commit  - parallel shift applied, result register loaded
    sust_pkg::cmd_t cmd;

    sust_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // the datapath holds the entry array, count, and the result register
    sust_dp u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .action (action),
        .value  (value),
        .hit    (hit),
        .status (status),
        .count  (count)
    );

endmodule

>>> rtl/sust_ctrl.sv
// ----------------------------------------------------------------------------
// sust_ctrl: request sequencer
// Two-state machine: accept/compare, then commit into the result register.
// ----------------------------------------------------------------------------
module sust_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output sust_pkg::cmd_t  cmd
);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    assign cmd.capture = in_valid && (state_reg == S_IDLE);
    assign cmd.commit  = (state_reg == S_UPDATE) && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (slot_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a new result only appears out of the update state
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_UPDATE))
        else $error("result raised outside update");

    // one item at a time: accept blocks the input for the next cycle
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> !in_ready)
        else $error("input accepted while busy");

    // commit never overwrites a result still waiting
    a_commit_safe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit over pending result");

endmodule

>>> rtl/sust_dp.sv
// ----------------------------------------------------------------------------
// sust_dp: register-array datapath
// Parallel compare of the key against every held entry, then a parallel
// shift for insert/remove and the result register.
// ----------------------------------------------------------------------------
module sust_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sust_pkg::cmd_t                       cmd,
    input  logic        [sust_pkg::ACT_W-1:0]    action,
    input  logic signed [sust_pkg::VAL_W-1:0]    value,
    output logic                                 hit,
    output logic                                 status,
    output logic        [sust_pkg::OUT_CNT_W-1:0] count
);

    logic signed [sust_pkg::VAL_W-1:0] entries_reg [sust_pkg::CAPACITY];
    logic signed [sust_pkg::VAL_W-1:0] key_reg;
    logic        [sust_pkg::ACT_W-1:0] act_reg;
    logic        [sust_pkg::CAPACITY-1:0] lt_reg;
    logic        [sust_pkg::CAPACITY-1:0] eq_reg;
    logic        [sust_pkg::CAPACITY-1:0] lt_next;
    logic        [sust_pkg::CAPACITY-1:0] eq_next;
    logic        [sust_pkg::CNT_W-1:0]    size_reg;
    logic        [sust_pkg::CNT_W-1:0]    size_next;
    logic                                 hit_reg;
    logic                                 status_reg;
    logic        [sust_pkg::OUT_CNT_W-1:0] count_reg;
    logic                                 found;
    logic                                 full;
    logic                                 do_ins;
    logic                                 do_rem;

    // compare on the incoming key, masked to the occupied region
    always_comb
    begin
        for (int i = 0; i < sust_pkg::CAPACITY; i++)
        begin
            lt_next[i] = (sust_pkg::CNT_W'(i) < size_reg) && (entries_reg[i] < value);
            eq_next[i] = (sust_pkg::CNT_W'(i) < size_reg) && (entries_reg[i] == value);
        end
    end

    assign found  = |eq_reg;
    assign full   = (size_reg == sust_pkg::CNT_W'(sust_pkg::CAPACITY));
    assign do_ins = (act_reg == sust_pkg::ACT_INSERT) && !found && !full;
    assign do_rem = (act_reg == sust_pkg::ACT_REMOVE) && found;

    always_comb
    begin
        size_next = size_reg;
        if (do_ins)
        begin
            size_next = size_reg + 1'b1;
        end
        else if (do_rem)
        begin
            size_next = size_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
            lt_reg   <= '0;
            eq_reg   <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                lt_reg <= lt_next;
                eq_reg <= eq_next;
            end
            if (cmd.commit)
            begin
                size_reg <= size_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= value;
            act_reg <= action;
        end
        if (cmd.commit)
        begin
            hit_reg    <= found;
            status_reg <= (act_reg == sust_pkg::ACT_INSERT) && !found && full;
            count_reg  <= sust_pkg::OUT_CNT_W'(size_next);
        end
    end

    // lt_reg is a thermometer: entries below the slot keep their place
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < sust_pkg::CAPACITY; i++)
        begin
            if (cmd.commit && do_ins && !lt_reg[i])
            begin
                if (i == 0)
                begin
                    entries_reg[i] <= key_reg;
                end
                else if (lt_reg[(i == 0) ? 0 : i - 1])
                begin
                    entries_reg[i] <= key_reg;
                end
                else
                begin
                    entries_reg[i] <= entries_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (cmd.commit && do_rem && !lt_reg[i] && (i < sust_pkg::CAPACITY - 1))
            begin
                entries_reg[i] <=
                    entries_reg[(i < sust_pkg::CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    assign hit    = hit_reg;
    assign status = status_reg;
    assign count  = count_reg;

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= sust_pkg::CNT_W'(sust_pkg::CAPACITY))
        else $error("size over capacity");

    // sorted store: less-than vector is contiguous from the bottom
    a_lt_thermo: assert property (@(posedge clk) disable iff (!rst_n)
        ((lt_reg + 1'b1) & lt_reg) == '0)
        else $error("store not sorted");

    a_eq_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_reg))
        else $error("duplicate key in store");

endmodule
